@@ design/nirp_pkg.sv @@
// nirp_pkg: shared types, register indexes and constants for the NEC IR pulse decoder
// no dependencies; imported by every module of the block
package nirp_pkg;

  // code length and derived widths
  localparam int CODE_BITS = 32;
  localparam int KEY_W     = 32;
  localparam int LEN_W     = 16;
  localparam int BIT_CNT_W = $clog2(CODE_BITS + 1);

  // classification queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_LOW_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_LOW_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPACE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPACE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_THRESH   = 3'd6;

  // register reset values, microseconds
  localparam logic [LEN_W-1:0] RST_LEADER_LOW_MIN   = 16'd8000;
  localparam logic [LEN_W-1:0] RST_LEADER_LOW_MAX   = 16'd10000;
  localparam logic [LEN_W-1:0] RST_REPEAT_SPACE_MIN = 16'd2000;
  localparam logic [LEN_W-1:0] RST_REPEAT_SPACE_MAX = 16'd2500;
  localparam logic [LEN_W-1:0] RST_START_SPACE_MIN  = 16'd4000;
  localparam logic [LEN_W-1:0] RST_START_SPACE_MAX  = 16'd5000;
  localparam logic [LEN_W-1:0] RST_ONE_BIT_THRESH   = 16'd1000;

  // frame status codes
  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_REPEAT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  // input word
  typedef struct packed {
    logic             pulse_level;
    logic [LEN_W-1:0] pulse_length;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]       frame_status;
    logic [KEY_W-1:0] key_code;
  } out_word_t;

  // classified pulse handed from front to back
  typedef struct packed {
    logic level;
    logic leader_win;
    logic repeat_win;
    logic start_win;
    logic one_bit;
  } pulse_class_t;

  // queue handshake toward the back
  typedef struct packed {
    logic         valid;
    pulse_class_t word;
  } q_head_t;

  // decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LEADER = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

endpackage

@@ design/nec_ir_pulse_decoder_unit.sv @@
// NEC IR pulse decoder, top level: one measured pulse in per word, at most one frame result out.
// The block takes one pulse word every clock cycle while the queue has room. The front compares
// the pulse length with the timing windows in the same cycle it accepts the word and writes the
// result into a two-entry queue; the back runs the frame state machine on one queued pulse per
// cycle unless the output stalls and loads the result register. The input stalls only when the
// queue is full, which happens only after a stalled output has held the result register.
// Configuration writes take effect on the next cycle.
// depends on nirp_pkg, nirp_front, nirp_queue, nirp_back
module nec_ir_pulse_decoder_unit import nirp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  logic         cls_valid;
  logic         cls_ready;
  pulse_class_t cls_word;
  q_head_t      q_head;
  logic         q_pop;

  // classify
  nirp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_word  (cls_word)
  );

  // decouple
  nirp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_word  (cls_word),
    .head       (q_head),
    .pop        (q_pop)
  );

  // decode frames
  nirp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ design/nirp_front.sv @@
// nirp_front: configuration registers and pulse classification against the timing windows
// depends on nirp_pkg
module nirp_front import nirp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 cls_valid,
  input  logic                 cls_ready,
  output pulse_class_t         cls_word
);

  logic [LEN_W-1:0] leader_min_r, leader_max_r;
  logic [LEN_W-1:0] repeat_min_r, repeat_max_r;
  logic [LEN_W-1:0] start_min_r, start_max_r;
  logic [LEN_W-1:0] one_thresh_r;
  logic [LEN_W-1:0] len;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_min_r <= RST_LEADER_LOW_MIN;
      leader_max_r <= RST_LEADER_LOW_MAX;
      repeat_min_r <= RST_REPEAT_SPACE_MIN;
      repeat_max_r <= RST_REPEAT_SPACE_MAX;
      start_min_r  <= RST_START_SPACE_MIN;
      start_max_r  <= RST_START_SPACE_MAX;
      one_thresh_r <= RST_ONE_BIT_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEADER_LOW_MIN:   leader_min_r <= cfg_wdata;
        REG_LEADER_LOW_MAX:   leader_max_r <= cfg_wdata;
        REG_REPEAT_SPACE_MIN: repeat_min_r <= cfg_wdata;
        REG_REPEAT_SPACE_MAX: repeat_max_r <= cfg_wdata;
        REG_START_SPACE_MIN:  start_min_r  <= cfg_wdata;
        REG_START_SPACE_MAX:  start_max_r  <= cfg_wdata;
        REG_ONE_BIT_THRESH:   one_thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window compares
  assign len = in_word.pulse_length;

  always_comb begin
    cls_word.level      = in_word.pulse_level;
    cls_word.leader_win = (len >= leader_min_r) && (len <= leader_max_r);
    cls_word.repeat_win = (len >  repeat_min_r) && (len <  repeat_max_r);
    cls_word.start_win  = (len >= start_min_r)  && (len <= start_max_r);
    cls_word.one_bit    = (len >  one_thresh_r);
  end

  // handshake follows queue space
  assign cls_valid = in_valid;
  assign in_ready  = cls_ready;

endmodule

@@ design/nirp_queue.sv @@
// nirp_queue: short fifo of classified pulses between front and back
// depends on nirp_pkg
module nirp_queue import nirp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  pulse_class_t push_word,
  output q_head_t      head,
  input  logic         pop
);

  pulse_class_t          entry_r [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]       count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.word  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

@@ design/nirp_back.sv @@
// nirp_back: frame state machine, bit shifter and result register
// depends on nirp_pkg
module nirp_back import nirp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  phase_t                 phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0]   bits_r, bits_nxt, bits_inc;
  logic [KEY_W-1:0]       shift_r, shift_nxt, shift_in;
  logic [KEY_W-1:0]       last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;
  logic                   emit;
  out_word_t              emit_word;
  pulse_class_t           c;

  // take a pulse whenever the result register is free or draining
  assign pop = head.valid && (!out_valid_r || out_ready);
  assign c   = head.word;

  assign bits_inc = bits_r + 1'b1;
  assign shift_in = {shift_r[KEY_W-2:0], c.one_bit};

  // frame decode
  always_comb begin
    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    emit      = 1'b0;
    emit_word = '{frame_status: ST_NEW, key_code: '0};
    if (pop) begin
      case (phase_r)
        PH_LEADER: begin
          if (!c.level) begin
            phase_nxt = c.leader_win ? PH_LEADER : PH_IDLE;
          end else if (c.repeat_win) begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            emit_word = '{frame_status: ST_REPEAT, key_code: last_r};
          end else if (c.start_win) begin
            phase_nxt = PH_DATA;
            bits_nxt  = '0;
            shift_nxt = '0;
          end else begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            emit_word = '{frame_status: ST_BAD, key_code: '0};
          end
        end
        PH_DATA: begin
          if (c.level) begin
            shift_nxt = shift_in;
            if (bits_inc >= BIT_CNT_W'(CODE_BITS)) begin
              last_nxt  = shift_in;
              phase_nxt = PH_IDLE;
              bits_nxt  = '0;
              emit      = 1'b1;
              emit_word = '{frame_status: ST_NEW, key_code: shift_in};
            end else begin
              bits_nxt = bits_inc;
            end
          end
        end
        default: begin
          phase_nxt = (!c.level && c.leader_win) ? PH_LEADER : PH_IDLE;
        end
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = emit_word;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bits_r      <= '0;
      shift_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ design/nirp_checker.sv @@
// nirp_checker: port-level assertions for the NEC IR pulse decoder, bound to the top level
// depends on nirp_pkg and nec_ir_pulse_decoder_unit
module nirp_checker import nirp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_word_t            out_word
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.frame_status == ST_NEW || out_word.frame_status == ST_REPEAT ||
                   out_word.frame_status == ST_BAD))
    else $error("undefined frame status");

  // a bad frame start carries no code
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_status == ST_BAD |-> out_word.key_code == '0)
    else $error("bad start result with nonzero code");

  // reset empties the result register and the queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // a result needs the queue to have held a pulse, so none right after reset
  a_no_early_result: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |=> !out_valid)
    else $error("result without a preceding pulse");

endmodule

bind nec_ir_pulse_decoder_unit nirp_checker u_nirp_checker (.*);

@@ verif/nec_ir_pulse_decoder_unit_tb.sv @@
// testbench for nec_ir_pulse_decoder_unit: pulse words in, frame results checked in order
// depends on nirp_pkg and the decoder rtl; self-contained predictor, no files or arguments
`timescale 1ns / 100ps

module nec_ir_pulse_decoder_unit_tb import nirp_pkg::*; ();

  // write to an index past the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int MIN_WORDS     = 700;
  localparam int MIN_FRAMES    = 48;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;

  // pending pulse words and expected frame results
  in_word_t  pulse_fifo[$];
  out_word_t expected_frames[$];
  int        words_queued = 0;
  int        words_taken = 0;
  int        frames_due = 0;
  int        mismatch_count = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  // predictor copy of the timing windows and the frame decoder state
  logic [LEN_W-1:0] win_cfg [NUM_REGS];
  phase_t           dec_phase = PH_IDLE;
  int               bit_count = 0;
  logic [KEY_W-1:0] shift_key = '0;
  logic [KEY_W-1:0] last_key = '0;

  nec_ir_pulse_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit in_leader_win(logic [LEN_W-1:0] len);
    return len >= win_cfg[REG_LEADER_LOW_MIN] && len <= win_cfg[REG_LEADER_LOW_MAX];
  endfunction

  // frame state machine, one accepted pulse word at a time
  function automatic void decode_pulse(in_word_t w);
    logic             have;
    out_word_t        r;
    logic [LEN_W-1:0] len;
    have = 1'b0;
    r = '0;
    len = w.pulse_length;
    case (dec_phase)
      PH_LEADER: begin
        if (!w.pulse_level) begin
          dec_phase = in_leader_win(len) ? PH_LEADER : PH_IDLE;
        end else if (len > win_cfg[REG_REPEAT_SPACE_MIN] &&
                     len < win_cfg[REG_REPEAT_SPACE_MAX]) begin
          dec_phase = PH_IDLE;
          r.frame_status = ST_REPEAT;
          r.key_code = last_key;
          have = 1'b1;
        end else if (len >= win_cfg[REG_START_SPACE_MIN] &&
                     len <= win_cfg[REG_START_SPACE_MAX]) begin
          dec_phase = PH_DATA;
          bit_count = 0;
          shift_key = '0;
        end else begin
          dec_phase = PH_IDLE;
          r.frame_status = ST_BAD;
          r.key_code = '0;
          have = 1'b1;
        end
      end
      PH_DATA: begin
        if (w.pulse_level) begin
          shift_key = {shift_key[KEY_W-2:0], len > win_cfg[REG_ONE_BIT_THRESH]};
          bit_count++;
          if (bit_count >= CODE_BITS) begin
            last_key = shift_key;
            dec_phase = PH_IDLE;
            bit_count = 0;
            r.frame_status = ST_NEW;
            r.key_code = shift_key;
            have = 1'b1;
          end
        end
      end
      default: begin
        dec_phase = (!w.pulse_level && in_leader_win(len)) ? PH_LEADER : PH_IDLE;
      end
    endcase
    if (have) begin
      expected_frames.push_back(r);
      frames_due++;
    end
  endfunction

  // input driver: random idle bursts, holds the word until taken
  always @(posedge clk) begin : drv
    logic     nxt_valid;
    in_word_t nxt_word;
    nxt_valid = in_valid;
    nxt_word = in_word;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_pulse(in_word);
        words_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pulse_fifo.size() != 0) begin
          if (!calm && $urandom_range(7, 0) == 0) begin
            in_gap = $urandom_range(8, 0);
          end else begin
            nxt_valid = 1'b1;
            nxt_word = pulse_fifo.pop_front();
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_word <= nxt_word;
  end

  // result monitor: random stall bursts, compare against oldest expectation
  always @(posedge clk) begin : mon
    logic      nxt_ready;
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result word: frame_status %0d key_code %h",
               out_word.frame_status, out_word.key_code);
        mismatch_count++;
      end else begin
        exp_w = expected_frames.pop_front();
        if (out_word.frame_status !== exp_w.frame_status) begin
          $error("frame_status expected %0d actual %0d",
                 exp_w.frame_status, out_word.frame_status);
          mismatch_count++;
        end
        if (out_word.key_code !== exp_w.key_code) begin
          $error("key_code expected %h actual %h", exp_w.key_code, out_word.key_code);
          mismatch_count++;
        end
      end
    end
    if (calm) begin
      nxt_ready = 1'b1;
    end else if (out_gap != 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(7, 0) == 0) begin
      out_gap = $urandom_range(8, 0);
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ready <= nxt_ready;
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_pulse(input logic lvl, input logic [LEN_W-1:0] len);
    in_word_t w;
    w.pulse_level = lvl;
    w.pulse_length = len;
    pulse_fifo.push_back(w);
    words_queued++;
  endtask

  // value inside [lo, hi], often an edge; anything when the window is empty
  function automatic logic [LEN_W-1:0] pick_in(int lo, int hi);
    if (lo > hi) return LEN_W'($urandom_range(LEN_MAX, 0));
    case ($urandom_range(3, 0))
      0: return LEN_W'(lo);
      1: return LEN_W'(hi);
      default: return LEN_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] leader_len();
    return pick_in(int'(win_cfg[REG_LEADER_LOW_MIN]), int'(win_cfg[REG_LEADER_LOW_MAX]));
  endfunction

  function automatic logic [LEN_W-1:0] start_len();
    return pick_in(int'(win_cfg[REG_START_SPACE_MIN]), int'(win_cfg[REG_START_SPACE_MAX]));
  endfunction

  // repeat window is open on both ends
  function automatic logic [LEN_W-1:0] repeat_len();
    return pick_in(int'(win_cfg[REG_REPEAT_SPACE_MIN]) + 1,
                   int'(win_cfg[REG_REPEAT_SPACE_MAX]) - 1);
  endfunction

  function automatic logic [LEN_W-1:0] bit_len(logic one);
    if (one) return pick_in(int'(win_cfg[REG_ONE_BIT_THRESH]) + 1, int'(LEN_MAX));
    return pick_in(0, int'(win_cfg[REG_ONE_BIT_THRESH]));
  endfunction

  // one random sequence: about half clean frames, the rest repeats, bad starts, noise and broken frames
  task automatic add_sequence();
    int               kind;
    int               n;
    logic [KEY_W-1:0] key;
    kind = $urandom_range(9, 0);
    if (kind <= 4) begin
      push_pulse(1'b0, leader_len());
      if ($urandom_range(5, 0) == 0) push_pulse(1'b0, leader_len());
      push_pulse(1'b1, start_len());
      case ($urandom_range(5, 0))
        0: key = '0;
        1: key = '1;
        default: key = $urandom;
      endcase
      for (int i = CODE_BITS - 1; i >= 0; i--) begin
        if ($urandom_range(1, 0)) push_pulse(1'b0, LEN_W'($urandom_range(LEN_MAX, 0)));
        push_pulse(1'b1, bit_len(key[i]));
      end
    end else if (kind <= 6) begin
      push_pulse(1'b0, leader_len());
      push_pulse(1'b1, repeat_len());
    end else if (kind == 7) begin
      push_pulse(1'b0, leader_len());
      push_pulse(1'b1, LEN_W'($urandom_range(LEN_MAX, 0)));
    end else if (kind == 8) begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        case ($urandom_range(3, 0))
          0: push_pulse(1'($urandom_range(1, 0)), 16'd0);
          1: push_pulse(1'($urandom_range(1, 0)), LEN_MAX);
          default: push_pulse(1'($urandom_range(1, 0)), LEN_W'($urandom_range(LEN_MAX, 0)));
        endcase
      end
    end else begin
      // broken frame: extra lows after the leader, some outside the window
      push_pulse(1'b0, leader_len());
      n = $urandom_range(3, 1);
      repeat (n) begin
        if ($urandom_range(1, 0)) push_pulse(1'b0, leader_len());
        else push_pulse(1'b0, LEN_W'($urandom_range(LEN_MAX, 0)));
      end
      push_pulse(1'b1, LEN_W'($urandom_range(LEN_MAX, 0)));
    end
  endtask

  task automatic add_traffic(input int n_words);
    int target;
    target = words_queued + n_words;
    while (words_queued < target) add_sequence();
  endtask

  // wait for every word taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk);
    while (words_taken != words_queued || expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < NUM_REGS) win_cfg[idx] = val;
  endtask

  task automatic set_windows(input logic [LEN_W-1:0] lmin, lmax, rmin, rmax, smin, smax, thr);
    write_reg(REG_LEADER_LOW_MIN, lmin);
    write_reg(REG_LEADER_LOW_MAX, lmax);
    write_reg(REG_REPEAT_SPACE_MIN, rmin);
    write_reg(REG_REPEAT_SPACE_MAX, rmax);
    write_reg(REG_START_SPACE_MIN, smin);
    write_reg(REG_START_SPACE_MAX, smax);
    write_reg(REG_ONE_BIT_THRESH, thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] upper_of(logic [LEN_W-1:0] lo);
    int hi;
    hi = int'(lo) + $urandom_range(6000, 0);
    return (hi > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(hi);
  endfunction

  // one register setting per mode, extremes and odd windows included
  task automatic configure(input int mode);
    logic [LEN_W-1:0] a, b, c, d;
    case (mode)
      1: begin
        write_reg(REG_UNUSED, LEN_W'($urandom_range(LEN_MAX, 0)));
        set_windows(RST_LEADER_LOW_MIN, RST_LEADER_LOW_MAX, RST_REPEAT_SPACE_MIN,
                    RST_REPEAT_SPACE_MAX, RST_START_SPACE_MIN, RST_START_SPACE_MAX,
                    RST_ONE_BIT_THRESH);
      end
      2: set_windows('0, '0, '0, '0, '0, '0, '0);
      3: set_windows(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
      // repeat and start windows empty, every decided frame is bad
      4: set_windows(16'd100, 16'd900, 16'd5000, 16'd3000, 16'd6000, 16'd5999, 16'd500);
      // repeat window overlaps the lower part of the start window
      5: set_windows(16'd3000, 16'd3100, 16'd1000, 16'd6000, 16'd5000, 16'd7000, 16'd300);
      default: begin
        a = LEN_W'($urandom_range(LEN_MAX, 0));
        b = LEN_W'($urandom_range(LEN_MAX, 0));
        c = LEN_W'($urandom_range(LEN_MAX, 0));
        d = LEN_W'($urandom_range(LEN_MAX, 0));
        set_windows(a, upper_of(a), b, upper_of(b), c, upper_of(c), d);
      end
    endcase
  endtask

  initial begin
    win_cfg[REG_LEADER_LOW_MIN]   = RST_LEADER_LOW_MIN;
    win_cfg[REG_LEADER_LOW_MAX]   = RST_LEADER_LOW_MAX;
    win_cfg[REG_REPEAT_SPACE_MIN] = RST_REPEAT_SPACE_MIN;
    win_cfg[REG_REPEAT_SPACE_MAX] = RST_REPEAT_SPACE_MAX;
    win_cfg[REG_START_SPACE_MIN]  = RST_START_SPACE_MIN;
    win_cfg[REG_START_SPACE_MAX]  = RST_START_SPACE_MAX;
    win_cfg[REG_ONE_BIT_THRESH]   = RST_ONE_BIT_THRESH;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset windows
    push_pulse(1'b1, 16'd9000);   // high while idle is ignored
    push_pulse(1'b0, 16'd7999);   // just below leader window
    push_pulse(1'b0, 16'd10001);  // just above leader window
    push_pulse(1'b0, 16'd8000);
    push_pulse(1'b1, 16'd2250);   // repeat before any code gives zero
    push_pulse(1'b0, 16'd10000);
    push_pulse(1'b0, 16'd9000);   // second leader low keeps it armed
    push_pulse(1'b0, 16'd0);      // low outside window drops back to idle
    push_pulse(1'b1, 16'd2250);
    push_pulse(1'b0, 16'd8000);
    push_pulse(1'b1, 16'd2000);   // repeat window edges are exclusive
    push_pulse(1'b0, 16'd8000);
    push_pulse(1'b1, 16'd2500);
    push_pulse(1'b0, 16'd9000);
    push_pulse(1'b1, 16'd3999);
    push_pulse(1'b0, 16'd9000);
    push_pulse(1'b1, 16'd5001);
    push_pulse(1'b0, 16'd9000);
    push_pulse(1'b1, LEN_MAX);
    push_pulse(1'b0, 16'd8500);
    push_pulse(1'b1, 16'd4000);   // start window lower edge
    push_pulse(1'b0, LEN_MAX);    // lows skipped in data
    push_pulse(1'b1, 16'd1000);   // threshold itself is a zero
    push_pulse(1'b1, 16'd1001);
    push_pulse(1'b1, 16'd0);
    push_pulse(1'b1, LEN_MAX);
    repeat (CODE_BITS - 4) push_pulse(1'b1, bit_len(1'($urandom_range(1, 0))));
    push_pulse(1'b0, 16'd9000);
    push_pulse(1'b1, 16'd2001);   // repeat of the code just decoded
    add_traffic(80);
    wait_drained();

    // random traffic over a series of register settings
    for (int mode = 1; mode <= 6 || words_queued < MIN_WORDS || frames_due < MIN_FRAMES;
         mode++) begin
      configure(mode);
      add_traffic(60);
      wait_drained();
    end

    // last stretch at reset windows without idling
    calm = 1'b1;
    configure(1);
    add_traffic(60);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
